[rtl/spl_pkg.sv]
`default_nettype none

package spl_pkg;

    localparam int VALUE_W      = 32;
    localparam int OP_W         = 2;
    localparam int OUT_CNT_W    = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DEDUP  = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef struct packed {
        logic accept;
        logic run_ins;
        logic run_ded;
        logic run_srch;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic small_list;
        logic ins_done;
        logic ded_done;
        logic srch_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/spl_ram.sv]
`default_nettype none

module spl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/spl_ctrl.sv]
`default_nettype none

module spl_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic [spl_pkg::OP_W-1:0] i_op,
    input  wire spl_pkg::t_sts           i_sts,
    output spl_pkg::t_cmd                o_cmd,
    output logic                         o_in_stall
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_DED  = 5'b00100,
        S_SRCH = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        spl_pkg::OP_INSERT: n_state = i_sts.full ? S_DONE : S_INS;
                        spl_pkg::OP_DEDUP:  n_state = i_sts.small_list ? S_DONE : S_DED;
                        spl_pkg::OP_SEARCH: n_state = S_SRCH;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                o_cmd.run_ins = 1'b1;
                if (i_sts.ins_done) begin
                    n_state = S_DONE;
                end
            end
            S_DED: begin
                o_cmd.run_ded = 1'b1;
                if (i_sts.ded_done) begin
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                o_cmd.run_srch = 1'b1;
                if (i_sts.srch_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/spl_dp.sv]
`default_nettype none

module spl_dp #(
    parameter int CAPACITY = spl_pkg::CAPACITY_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spl_pkg::t_cmd                     i_cmd,
    output spl_pkg::t_sts                          o_sts,
    input  wire logic [spl_pkg::OP_W-1:0]          i_op,
    input  wire logic signed [spl_pkg::VALUE_W-1:0] i_value,
    input  wire logic                              i_out_stall,
    output logic                                   o_out_valid,
    output logic                                   o_found,
    output logic [spl_pkg::OUT_CNT_W-1:0]          o_position,
    output logic [spl_pkg::OUT_CNT_W-1:0]          o_entry_total,
    output logic                                   o_status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = CNT_W + spl_pkg::OUT_CNT_W;

    logic signed [spl_pkg::VALUE_W-1:0] r_value;
    logic [spl_pkg::VALUE_W-1:0]        r_last;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   r_rd;
    logic [CNT_W-1:0]                   r_w;
    logic [IDX_W-1:0]                   r_cmp;
    logic                               r_dvalid;
    logic                               r_found;
    logic [CNT_W-1:0]                   r_pos;
    logic                               r_status;

    logic                               r_out_valid;
    logic                               r_o_found;
    logic [spl_pkg::OUT_CNT_W-1:0]      r_o_pos;
    logic [spl_pkg::OUT_CNT_W-1:0]      r_o_total;
    logic                               r_o_status;

    logic                               running;
    logic                               rd_more;
    logic [CNT_W-1:0]                   rd_dec;
    logic [IDX_W-1:0]                   rd_addr;
    logic [spl_pkg::VALUE_W-1:0]        rdata;
    logic                               greater;
    logic                               hit;
    logic                               we;
    logic [IDX_W-1:0]                   waddr;
    logic [spl_pkg::VALUE_W-1:0]        wdata;
    logic [EXT_W-1:0]                   pos_ext;
    logic [EXT_W-1:0]                   total_ext;

    assign running = i_cmd.run_ins | i_cmd.run_ded | i_cmd.run_srch;
    assign rd_dec  = r_rd - CNT_W'(1);

    // insert walks down from the tail, the other two walk up from the head
    assign rd_more = i_cmd.run_ins ? (r_rd != '0) : (r_rd < r_count);
    assign rd_addr = i_cmd.run_ins ? rd_dec[IDX_W-1:0] : r_rd[IDX_W-1:0];

    assign greater = $signed(rdata) > r_value;
    assign hit     = i_cmd.run_srch & r_dvalid & (rdata == r_value);

    always_comb begin
        we    = 1'b0;
        waddr = r_w[IDX_W-1:0];
        wdata = rdata;
        if (i_cmd.run_ins) begin
            // shift larger entries up one slot, drop the value into the gap
            we    = r_dvalid | ~rd_more;
            waddr = r_dvalid ? (r_cmp + IDX_W'(1)) : '0;
            wdata = (r_dvalid & greater) ? rdata : r_value;
        end else if (i_cmd.run_ded) begin
            we = r_dvalid & (r_cmp != '0) & (rdata != r_last);
        end
    end

    spl_ram #(
        .WIDTH(spl_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rdata)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.full       = (r_count == CNT_W'(CAPACITY));
        o_sts.small_list = (r_count <= CNT_W'(1));
        o_sts.ins_done   = i_cmd.run_ins & (r_dvalid ? ~greater : ~rd_more);
        o_sts.ded_done   = i_cmd.run_ded & ~r_dvalid & ~rd_more;
        o_sts.srch_done  = i_cmd.run_srch & (hit | (~r_dvalid & ~rd_more));
        o_sts.out_free   = ~r_out_valid | ~i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_dvalid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_dvalid <= 1'b0;
            end else if (running) begin
                r_dvalid <= rd_more;
            end
            if (o_sts.ins_done) begin
                r_count <= r_count + CNT_W'(1);
            end else if (o_sts.ded_done) begin
                r_count <= r_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value  <= i_value;
            r_rd     <= (i_op == spl_pkg::OP_INSERT) ? r_count : '0;
            r_w      <= CNT_W'(1);
            r_found  <= 1'b0;
            r_pos    <= '0;
            r_status <= (i_op == spl_pkg::OP_INSERT) && o_sts.full;
        end else begin
            if (running && rd_more) begin
                r_rd <= i_cmd.run_ins ? rd_dec : (r_rd + CNT_W'(1));
            end
            if (running) begin
                r_cmp <= rd_addr;
            end
            if (i_cmd.run_ded && r_dvalid) begin
                if (r_cmp == '0) begin
                    r_last <= rdata;
                end else if (rdata != r_last) begin
                    r_last <= rdata;
                    r_w    <= r_w + CNT_W'(1);
                end
            end
            if (hit) begin
                r_found <= 1'b1;
                r_pos   <= CNT_W'(r_cmp) + CNT_W'(1);
            end
        end
    end

    assign pos_ext   = {{spl_pkg::OUT_CNT_W{1'b0}}, r_pos};
    assign total_ext = {{spl_pkg::OUT_CNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_found  <= r_found;
            r_o_pos    <= pos_ext[spl_pkg::OUT_CNT_W-1:0];
            r_o_total  <= total_ext[spl_pkg::OUT_CNT_W-1:0];
            r_o_status <= r_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_o_found;
    assign o_position    = r_o_pos;
    assign o_entry_total = r_o_total;
    assign o_status      = r_o_status;

endmodule

`default_nettype wire

[rtl/sorted_priority_list_top.sv]
`default_nettype none

// channel   valid         stall         payload
// request   i_in_valid    o_in_stall    i_op, i_value
// result    o_out_valid   i_out_stall   o_found, o_position, o_entry_total, o_status
//
// one request at a time; each walks the entries through the single
// ram read port, one entry per cycle (a search stops early at its first hit)
// a dropped insert, an unknown op or a dedup of fewer than two entries skips the walk
// i_rst_n is synchronous; it empties the list, the ram contents are left as they are
// the next request is taken while a result waits in the output register under stall

module sorted_priority_list_top #(
    parameter int CAPACITY = spl_pkg::CAPACITY_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [spl_pkg::OP_W-1:0]          i_op,
    input  wire logic signed [spl_pkg::VALUE_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_found,
    output logic [spl_pkg::OUT_CNT_W-1:0]          o_position,
    output logic [spl_pkg::OUT_CNT_W-1:0]          o_entry_total,
    output logic                                   o_status
);

    spl_pkg::t_cmd cmd;
    spl_pkg::t_sts sts;

    spl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_op      (i_op),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    spl_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_entry_total(o_entry_total),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

[bench/spl_result_checker.sv]
`timescale 1ns / 100ps

module spl_result_checker #(
    parameter int CAPACITY = spl_pkg::CAPACITY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic [spl_pkg::OP_W-1:0]           i_op,
    input  wire logic signed [spl_pkg::VALUE_W-1:0] i_value,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_found,
    input  wire logic [spl_pkg::OUT_CNT_W-1:0]      i_position,
    input  wire logic [spl_pkg::OUT_CNT_W-1:0]      i_entry_total,
    input  wire logic                               i_status,
    output int                                      o_pending,
    output int                                      o_fail_count
);

    typedef struct packed {
        logic                          found;
        logic [spl_pkg::OUT_CNT_W-1:0] position;
        logic [spl_pkg::OUT_CNT_W-1:0] entry_total;
        logic                          status;
    } t_list_result;

    // shadow copy of the sorted store, ascending in entries 0 .. held-1
    logic signed [spl_pkg::VALUE_W-1:0] shadow_list [CAPACITY];
    int                                 held;
    t_list_result                       awaited_results [$];
    int                                 failures = 0;

    assign o_fail_count = failures;

    function automatic void predict_request(input logic [spl_pkg::OP_W-1:0] op,
                                            input logic signed [spl_pkg::VALUE_W-1:0] key);
        t_list_result res;
        int           slot;
        int           keep;
        res = '0;
        case (op)
            spl_pkg::OP_INSERT: begin
                if (held >= CAPACITY) begin
                    res.status = 1'b1;
                end else begin
                    // new value lands after every equal one
                    slot = 0;
                    while (slot < held && shadow_list[slot] <= key) slot++;
                    for (int w = held; w > slot; w--) shadow_list[w] = shadow_list[w-1];
                    shadow_list[slot] = key;
                    held++;
                end
            end
            spl_pkg::OP_DEDUP: begin
                if (held > 1) begin
                    keep = 1;
                    for (int r = 1; r < held; r++) begin
                        if (shadow_list[r] != shadow_list[keep-1]) begin
                            shadow_list[keep] = shadow_list[r];
                            keep++;
                        end
                    end
                    held = keep;
                end
            end
            spl_pkg::OP_SEARCH: begin
                for (slot = 0; slot < held; slot++) begin
                    if (shadow_list[slot] == key) begin
                        res.found    = 1'b1;
                        res.position = spl_pkg::OUT_CNT_W'(slot + 1);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_total = spl_pkg::OUT_CNT_W'(held);
        awaited_results.push_back(res);
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    function automatic void check_result();
        t_list_result want;
        if (awaited_results.size() == 0) begin
            $display("%0t: result with no request outstanding, expected none, actual %0d/%0d/%0d/%0d",
                     $time, i_found, i_position, i_entry_total, i_status);
            failures++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("found", want.found, i_found);
        compare_field("position", want.position, i_position);
        compare_field("entry_total", want.entry_total, i_entry_total);
        compare_field("status", want.status, i_status);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            // check before predicting so a result never matches its own cycle's request
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) predict_request(i_op, i_value);
            o_pending <= awaited_results.size();
        end
    end

endmodule

[bench/tb_sorted_priority_list_top.sv]
`timescale 1ns / 100ps

module tb_sorted_priority_list_top;

    localparam int                        CAPACITY     = spl_pkg::CAPACITY_DEF;
    localparam int                        RANDOM_ITEMS = 700;
    localparam int                        LONG_HOLD    = 300;
    localparam int                        TAIL_CYCLES  = CAPACITY + 16;
    localparam int                        LIMIT_CYCLES = 600000;
    localparam int                        POOL_SIZE    = 12;
    localparam logic [spl_pkg::OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam int                        PH_FILL      = 0;
    localparam int                        PH_SEARCH    = 1;
    localparam int                        PH_MIXED     = 2;
    localparam int                        PH_NOISE     = 3;
    localparam logic signed [spl_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [spl_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_in_valid    = 1'b0;
    logic                                o_in_stall;
    logic [spl_pkg::OP_W-1:0]            i_op          = '0;
    logic signed [spl_pkg::VALUE_W-1:0]  i_value       = '0;
    logic                                o_out_valid;
    logic                                i_out_stall   = 1'b0;
    logic                                o_found;
    logic [spl_pkg::OUT_CNT_W-1:0]       o_position;
    logic [spl_pkg::OUT_CNT_W-1:0]       o_entry_total;
    logic                                o_status;

    int                                  pending;
    int                                  fail_count;
    int                                  sent_total   = 0;
    int                                  cycle_count  = 0;
    bit                                  hold_off_req = 1'b0;
    logic signed [spl_pkg::VALUE_W-1:0]  value_pool [POOL_SIZE];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sorted_priority_list_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_entry_total(o_entry_total),
        .o_status     (o_status)
    );

    spl_result_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_found      (o_found),
        .i_position   (o_position),
        .i_entry_total(o_entry_total),
        .i_status     (o_status),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: clean stretches, mostly short stalls, and one long hold-off
    initial begin : result_sink
        int r;
        int run_len;
        int hold_count;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < LONG_HOLD) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                hold_off_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_stall <= 1'b0;
                    run_len = $urandom_range(0, 8);
                end else begin
                    i_out_stall <= 1'b1;
                    run_len = pick_gap();
                end
                repeat (run_len) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input logic [spl_pkg::OP_W-1:0] op,
                                input logic signed [spl_pkg::VALUE_W-1:0] value);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        sent_total++;
    endtask

    task automatic pause_sender(input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [spl_pkg::OP_W-1:0] pick_op(input int kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL: begin
                if (r < 80) return spl_pkg::OP_INSERT;
                if (r < 95) return spl_pkg::OP_SEARCH;
                if (r < 98) return spl_pkg::OP_DEDUP;
            end
            PH_SEARCH: begin
                if (r < 20) return spl_pkg::OP_INSERT;
                if (r < 90) return spl_pkg::OP_SEARCH;
                if (r < 97) return spl_pkg::OP_DEDUP;
            end
            PH_MIXED: begin
                if (r < 45) return spl_pkg::OP_INSERT;
                if (r < 70) return spl_pkg::OP_SEARCH;
                if (r < 95) return spl_pkg::OP_DEDUP;
            end
            default: begin
                return spl_pkg::OP_W'($urandom_range(0, 3));
            end
        endcase
        return OP_UNUSED;
    endfunction

    // inserts stay mostly inside the pool so dedup can shrink the list again
    function automatic logic signed [spl_pkg::VALUE_W-1:0] pick_value(
        input logic [spl_pkg::OP_W-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == spl_pkg::OP_INSERT ? r < 97 : r < 60) begin
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        end
        return $urandom;
    endfunction

    initial begin : stimulus
        int                        kind;
        int                        len;
        bit                        first;
        bit                        no_gaps;
        logic [spl_pkg::OP_W-1:0]  op;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, unknown op, extremes, duplicates, first-match search
        send_request(spl_pkg::OP_SEARCH, 32'sd0);            pause_sender(0);
        send_request(spl_pkg::OP_DEDUP, $urandom);           pause_sender(0);
        send_request(OP_UNUSED, 32'sd0);                     pause_sender(0);
        send_request(spl_pkg::OP_INSERT, 32'sd0);            pause_sender(0);
        send_request(spl_pkg::OP_INSERT, VAL_MAX);           pause_sender(0);
        send_request(spl_pkg::OP_INSERT, VAL_MIN);           pause_sender(0);
        send_request(spl_pkg::OP_INSERT, -32'sd1);           pause_sender(0);
        send_request(spl_pkg::OP_INSERT, 32'sd0);            pause_sender(0);
        send_request(spl_pkg::OP_INSERT, 32'sd0);            pause_sender(0);
        send_request(spl_pkg::OP_INSERT, VAL_MAX);           pause_sender(0);
        send_request(spl_pkg::OP_SEARCH, 32'sd0);            pause_sender(0);
        send_request(spl_pkg::OP_SEARCH, VAL_MIN);           pause_sender(0);
        send_request(spl_pkg::OP_SEARCH, VAL_MAX);           pause_sender(0);
        send_request(spl_pkg::OP_SEARCH, 32'sd1);            pause_sender(0);
        send_request(OP_UNUSED, -32'sd1);                    pause_sender(0);
        send_request(spl_pkg::OP_DEDUP, -32'sd1);            pause_sender(0);
        send_request(spl_pkg::OP_SEARCH, VAL_MAX);           pause_sender(0);
        send_request(spl_pkg::OP_SEARCH, VAL_MIN + 32'sd1);  pause_sender(0);
        send_request(spl_pkg::OP_DEDUP, 32'sd0);
        drain_results();

        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (int p = 5; p < POOL_SIZE; p++) value_pool[p] = $urandom;

        first = 1'b1;
        while (sent_total < RANDOM_ITEMS + 19) begin
            kind    = first ? PH_FILL : $urandom_range(PH_FILL, PH_NOISE);
            no_gaps = ($urandom_range(0, 3) == 0);
            case (kind)
                PH_FILL:   len = $urandom_range(40, 80);
                PH_SEARCH: len = $urandom_range(20, 40);
                PH_MIXED:  len = $urandom_range(10, 30);
                default:   len = $urandom_range(5, 15);
            endcase
            if (first) begin
                // overflow the list while the result side holds off
                len = CAPACITY + 8;
                hold_off_req = 1'b1;
            end
            for (int k = 0; k < len; k++) begin
                op = first ? spl_pkg::OP_INSERT : pick_op(kind);
                send_request(op, pick_value(op));
                if (k < len - 1) pause_sender(no_gaps);
            end
            if (first || $urandom_range(0, 99) < 30) drain_results();
            else pause_sender(no_gaps);
            first = 1'b0;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/spl_pkg.sv
rtl/spl_ram.sv
rtl/spl_ctrl.sv
rtl/spl_dp.sv
rtl/sorted_priority_list_top.sv
bench/spl_result_checker.sv
bench/tb_sorted_priority_list_top.sv
